@@ hdl/bist_pkg.sv @@
// Shared types, constants and command/status structs for the integer set table.
package bist_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_RM_RD,
        S_RM_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_action           action;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic             found;
        logic [IDX_W-1:0] position;
        logic [CNT_W-1:0] element_count;
        logic             is_full;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    clear;
        logic    add_wr;
        logic    rm_rd;
        logic    rm_wr;
        logic    set_status;
        t_status status;
        logic    finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    hit;
        logic    miss;
        logic    full;
        logic    out_busy;
    } t_sts;

endpackage

@@ hdl/bist_ctrl.sv @@
// Request sequencer: clear, or search then add or move-last-into-hole, then result.
module bist_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bist_pkg::t_sts i_sts,
    output bist_pkg::t_cmd o_cmd
);
    import bist_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                n_state = (i_sts.action == ACT_CLEAR) ? S_FINISH : S_SEARCH;
            end
            S_SEARCH: begin
                if (i_sts.hit && i_sts.action == ACT_REMOVE) begin
                    n_state = S_RM_RD;
                end else if (i_sts.hit || i_sts.miss) begin
                    n_state = S_FINISH;
                end
            end
            S_RM_RD: n_state = S_RM_WR;
            S_RM_WR: n_state = S_FINISH;
            S_FINISH: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.status = ST_DONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_START: begin
                if (i_sts.action == ACT_CLEAR) begin
                    o_cmd.clear      = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_SEARCH: begin
                if (i_sts.hit || i_sts.miss) begin
                    o_cmd.set_status = 1'b1;
                    unique case (i_sts.action)
                        ACT_ADD: begin
                            if (i_sts.hit) begin
                                o_cmd.status = ST_PRESENT;
                            end else if (i_sts.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.status = ST_DONE;
                                o_cmd.add_wr = 1'b1;
                            end
                        end
                        ACT_REMOVE, ACT_LOOKUP: begin
                            o_cmd.status = i_sts.hit ? ST_DONE : ST_NOTFOUND;
                        end
                        default: o_cmd.status = ST_DONE;
                    endcase
                end
            end
            S_RM_RD:  o_cmd.rm_rd  = 1'b1;
            S_RM_WR:  o_cmd.rm_wr  = 1'b1;
            S_FINISH: o_cmd.finish = !i_sts.out_busy;
            default: ;
        endcase
    end

endmodule

@@ hdl/bist_dp.sv @@
// Element store, count, capacity, search scanner and result register.
module bist_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bist_pkg::t_in_item         i_in_item,
    input  logic                       i_cfg_we,
    input  logic [bist_pkg::CNT_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bist_pkg::t_out_item        o_out_item,
    input  bist_pkg::t_cmd             i_cmd,
    output bist_pkg::t_sts             o_sts
);
    import bist_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    t_action          r_act;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_ridx;
    logic [IDX_W-1:0] r_pidx;
    logic [IDX_W-1:0] r_pos;
    logic             r_found;
    logic             r_scan;
    logic             r_pend;
    t_status          r_status;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] cnt_m1;
    logic             full;
    logic             hit;
    logic             miss;
    logic             issue;
    logic             rd_en;
    logic [IDX_W-1:0] raddr;

    assign cap_eff = (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
    assign full    = (r_count >= cap_eff);
    assign cnt_m1  = r_count - 1'b1;

    // compare happens in the cycle after the read issue (registered read)
    assign hit   = r_pend && (r_rdata == r_val);
    assign miss  = r_scan && !r_pend && (r_ridx >= r_count);
    assign issue = r_scan && !hit && (r_ridx < r_count);
    assign rd_en = issue || i_cmd.rm_rd;
    assign raddr = i_cmd.rm_rd ? cnt_m1[IDX_W-1:0] : r_ridx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= r_mem[raddr];
        if (i_cmd.add_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= r_val;
        end else if (i_cmd.rm_wr) begin
            r_mem[r_pos] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CNT_W'(DEPTH);
            r_scan      <= 1'b0;
            r_pend      <= 1'b0;
            r_ridx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;

            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.add_wr) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.rm_rd) begin
                r_count <= cnt_m1;
            end

            if (i_cmd.scan_start) begin
                r_scan <= 1'b1;
                r_pend <= 1'b0;
                r_ridx <= '0;
            end else if (hit || miss) begin
                r_scan <= 1'b0;
                r_pend <= 1'b0;
            end else begin
                r_pend <= issue;
                if (issue) r_ridx <= r_ridx + 1'b1;
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_in_item.action;
            r_val   <= i_in_item.value;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (hit) begin
            r_found <= 1'b1;
            r_pos   <= r_pidx;
        end
        if (issue) r_pidx <= r_ridx[IDX_W-1:0];
        if (i_cmd.set_status) r_status <= i_cmd.status;
        if (i_cmd.finish) begin
            r_out.status        <= r_status;
            r_out.found         <= r_found;
            r_out.position      <= r_pos;
            r_out.element_count <= r_count;
            r_out.is_full       <= full;
        end
    end

    always_comb begin
        o_sts.action   = r_act;
        o_sts.hit      = hit;
        o_sts.miss     = miss;
        o_sts.full     = full;
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ hdl/bounded_integer_set_table.sv @@
// Clear gives its result without a search; add and lookup scan the count elements,
// and remove then moves the last element into the hole; a hit ends the search early.
// Items are handled one at a time; the linear scan of the element store (one
// registered read a cycle) dominates the time taken per item.
// Reset (synchronous, active low): set empty, capacity DEPTH, no result pending;
// the element store is not cleared.
module bounded_integer_set_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bist_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bist_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_we,
    input  logic [bist_pkg::CNT_W-1:0] i_cfg_data
);
    import bist_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bist_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
